>>> rtl/lsi_pkg.sv
package lsi_pkg;

    // Coordinate format: signed Q16.16 words.
    localparam int CW = 32;
    // Endpoint differences.
    localparam int EW = CW + 1;
    // Cross products (denominator and the two numerators).
    localparam int DW = 2 * CW + 3;
    // Unscaled meeting point numerators.
    localparam int NW = 3 * CW + 5;
    // Offset rounding numerator.
    localparam int SW = 3 * CW + 7;
    // Divider remainder.
    localparam int RW = 3 * CW + 4;

    typedef struct packed {
        logic                 mode;
        logic signed [CW-1:0] first_start_x;
        logic signed [CW-1:0] first_start_y;
        logic signed [CW-1:0] first_end_x;
        logic signed [CW-1:0] first_end_y;
        logic signed [CW-1:0] second_start_x;
        logic signed [CW-1:0] second_start_y;
        logic signed [CW-1:0] second_end_x;
        logic signed [CW-1:0] second_end_y;
    } lsi_in_t;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] cross_x;
        logic signed [CW-1:0] cross_y;
        logic                 clipped;
    } lsi_out_t;

    // Word carried along the multiplier cells.
    typedef struct packed {
        logic                 hit;
        logic signed [DW-1:0] den;
        logic signed [DW-1:0] tn;
        logic signed [EW-1:0] ax;
        logic signed [EW-1:0] e1x;
        logic signed [EW-1:0] ay;
        logic signed [EW-1:0] e1y;
        logic signed [NW-1:0] nx;
        logic signed [NW-1:0] ny;
    } lsi_mul_t;

    // Word carried along the divider cells.
    typedef struct packed {
        logic          hit;
        logic [DW-1:0] den;
        logic [RW-1:0] rx;
        logic [RW-1:0] ry;
        logic [CW-1:0] qx;
        logic [CW-1:0] qy;
        logic          hi_x;
        logic          lo_x;
        logic          hi_y;
        logic          lo_y;
    } lsi_div_t;

endpackage

>>> rtl/lsi_front.sv
module lsi_front
    import lsi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  lsi_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output lsi_mul_t out_data
);

    typedef struct packed {
        logic                 mode;
        logic signed [EW-1:0] ax;
        logic signed [EW-1:0] ay;
        logic signed [EW-1:0] e1x;
        logic signed [EW-1:0] e1y;
        logic signed [EW-1:0] e2x;
        logic signed [EW-1:0] e2y;
        logic signed [EW-1:0] fx;
        logic signed [EW-1:0] fy;
    } diff_t;

    typedef struct packed {
        logic                   mode;
        logic signed [EW-1:0]   ax;
        logic signed [EW-1:0]   ay;
        logic signed [EW-1:0]   e1x;
        logic signed [EW-1:0]   e1y;
        logic signed [2*EW-1:0] p1;
        logic signed [2*EW-1:0] p2;
        logic signed [2*EW-1:0] p3;
        logic signed [2*EW-1:0] p4;
        logic signed [2*EW-1:0] p5;
        logic signed [2*EW-1:0] p6;
    } prod_t;

    typedef struct packed {
        logic                 mode;
        logic signed [EW-1:0] ax;
        logic signed [EW-1:0] ay;
        logic signed [EW-1:0] e1x;
        logic signed [EW-1:0] e1y;
        logic signed [DW-1:0] den;
        logic signed [DW-1:0] tn;
        logic signed [DW-1:0] un;
    } cross_t;

    diff_t    s1_reg, s1_next;
    prod_t    s2_reg, s2_next;
    cross_t   s3_reg, s3_next;
    lsi_mul_t s4_reg, s4_next;
    logic     v1_reg, v2_reg, v3_reg, v4_reg;
    logic     r1, r2, r3, r4;

    logic signed [DW-1:0] dn, tnn, unn;
    logic                 den_neg;

    // Each stage takes a word when it is empty or its successor takes one.
    assign r4       = !v4_reg || out_ready;
    assign r3       = !v3_reg || r4;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;

    // Direction vectors and the offset between the two start points.
    always_comb
    begin
        s1_next.mode = in_data.mode;
        s1_next.ax   = EW'(in_data.first_start_x);
        s1_next.ay   = EW'(in_data.first_start_y);
        s1_next.e1x  = EW'(in_data.first_end_x) - EW'(in_data.first_start_x);
        s1_next.e1y  = EW'(in_data.first_end_y) - EW'(in_data.first_start_y);
        s1_next.e2x  = EW'(in_data.second_end_x) - EW'(in_data.second_start_x);
        s1_next.e2y  = EW'(in_data.second_end_y) - EW'(in_data.second_start_y);
        s1_next.fx   = EW'(in_data.second_start_x) - EW'(in_data.first_start_x);
        s1_next.fy   = EW'(in_data.second_start_y) - EW'(in_data.first_start_y);
    end

    // The six partial cross products.
    always_comb
    begin
        s2_next.mode = s1_reg.mode;
        s2_next.ax   = s1_reg.ax;
        s2_next.ay   = s1_reg.ay;
        s2_next.e1x  = s1_reg.e1x;
        s2_next.e1y  = s1_reg.e1y;
        s2_next.p1   = s1_reg.e1x * s1_reg.e2y;
        s2_next.p2   = s1_reg.e1y * s1_reg.e2x;
        s2_next.p3   = s1_reg.fx * s1_reg.e2y;
        s2_next.p4   = s1_reg.fy * s1_reg.e2x;
        s2_next.p5   = s1_reg.fx * s1_reg.e1y;
        s2_next.p6   = s1_reg.fy * s1_reg.e1x;
    end

    // Denominator and the line parameters of both segments.
    always_comb
    begin
        s3_next.mode = s2_reg.mode;
        s3_next.ax   = s2_reg.ax;
        s3_next.ay   = s2_reg.ay;
        s3_next.e1x  = s2_reg.e1x;
        s3_next.e1y  = s2_reg.e1y;
        s3_next.den  = DW'(s2_reg.p1) - DW'(s2_reg.p2);
        s3_next.tn   = DW'(s2_reg.p3) - DW'(s2_reg.p4);
        s3_next.un   = DW'(s2_reg.p5) - DW'(s2_reg.p6);
    end

    // Make the denominator positive; in segment mode both parameters must lie in [0, 1].
    always_comb
    begin
        den_neg = s3_reg.den[DW-1];
        dn      = den_neg ? -s3_reg.den : s3_reg.den;
        tnn     = den_neg ? -s3_reg.tn : s3_reg.tn;
        unn     = den_neg ? -s3_reg.un : s3_reg.un;
        s4_next.hit = (s3_reg.den != '0) &&
                      (!s3_reg.mode || (!tnn[DW-1] && (tnn <= dn) &&
                                        !unn[DW-1] && (unn <= dn)));
        s4_next.den = dn;
        s4_next.tn  = tnn;
        s4_next.ax  = s3_reg.ax;
        s4_next.ay  = s3_reg.ay;
        s4_next.e1x = s3_reg.e1x;
        s4_next.e1y = s3_reg.e1y;
        s4_next.nx  = '0;
        s4_next.ny  = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (r1)
                v1_reg <= in_valid;
            if (r2)
                v2_reg <= v1_reg;
            if (r3)
                v3_reg <= v2_reg;
            if (r4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1 && in_valid)
            s1_reg <= s1_next;
        if (r2 && v1_reg)
            s2_reg <= s2_next;
        if (r3 && v2_reg)
            s3_reg <= s3_next;
        if (r4 && v3_reg)
            s4_reg <= s4_next;
    end

    assign out_valid = v4_reg;
    assign out_data  = s4_reg;

endmodule

>>> rtl/lsi_mul_cell.sv
module lsi_mul_cell
    import lsi_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  lsi_mul_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output lsi_mul_t out_data
);

    lsi_mul_t             data_reg, data_next;
    logic                 valid_reg;
    logic signed [NW-1:0] pd, pt, term_x, term_y;

    assign in_ready = !valid_reg || out_ready;

    // One multiplier bit of each coordinate; the top bit has negative weight.
    always_comb
    begin
        pd     = NW'(in_data.den) <<< IDX;
        pt     = NW'(in_data.tn) <<< IDX;
        term_x = (in_data.ax[IDX] ? pd : '0) + (in_data.e1x[IDX] ? pt : '0);
        term_y = (in_data.ay[IDX] ? pd : '0) + (in_data.e1y[IDX] ? pt : '0);
        data_next = in_data;
        if (IDX == EW - 1)
        begin
            data_next.nx = in_data.nx - term_x;
            data_next.ny = in_data.ny - term_y;
        end
        else
        begin
            data_next.nx = in_data.nx + term_x;
            data_next.ny = in_data.ny + term_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/lsi_div_cell.sv
module lsi_div_cell
    import lsi_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  lsi_div_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output lsi_div_t out_data
);

    lsi_div_t      data_reg, data_next;
    logic          valid_reg;
    logic [RW-1:0] ds;
    logic          gx, gy;

    assign in_ready = !valid_reg || out_ready;

    // One restoring step per coordinate against twice the denominator, shifted.
    always_comb
    begin
        ds        = RW'(in_data.den) << (IDX + 1);
        gx        = in_data.rx >= ds;
        gy        = in_data.ry >= ds;
        data_next = in_data;
        data_next.rx      = gx ? in_data.rx - ds : in_data.rx;
        data_next.ry      = gy ? in_data.ry - ds : in_data.ry;
        data_next.qx[IDX] = gx;
        data_next.qy[IDX] = gy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/line_segment_intersection_2d_top.sv
// Channel | Valid        | Stall        | Word
// pairs   | pair_valid   | pair_stall   | pair  (lsi_in_t, two segments and mode)
// points  | point_valid  | point_stall  | point (lsi_out_t, hit, point, clipped)
//
// One pair of segments is taken each cycle while pair_stall is low.
// The chain holds four front stages, 33 multiplier cells (one bit each),
// one rounding stage, 32 divider cells (one quotient bit each) and the output register.
// Reset clears only the valid bits; no clearing pass is needed.
// Each stage moves on when the stage after it is empty or moving, so bubbles fill up
// while point_stall is high and pair_stall rises only when every stage is full.
module line_segment_intersection_2d_top
    import lsi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     pair_valid,
    output logic     pair_stall,
    input  lsi_in_t  pair,
    output logic     point_valid,
    input  logic     point_stall,
    output lsi_out_t point
);

    lsi_mul_t mdat [EW+1];
    logic     mval [EW+1];
    logic     mrdy [EW+1];
    lsi_div_t ddat [CW+1];
    logic     dval [CW+1];
    logic     drdy [CW+1];
    logic     front_ready;

    lsi_div_t prep_reg, prep_next;
    logic     prep_valid_reg, prep_ready;
    lsi_out_t out_reg, out_next;
    logic     out_valid_reg, out_ready;

    logic signed [SW-1:0] nsx, nsy, lim;
    lsi_div_t             dlast;

    assign pair_stall = !front_ready;

    lsi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pair_valid),
        .in_ready  (front_ready),
        .in_data   (pair),
        .out_valid (mval[0]),
        .out_ready (mrdy[0]),
        .out_data  (mdat[0])
    );

    // Multiplier chain: nx = ax*den + e1x*tn, ny = ay*den + e1y*tn.
    for (genvar k = 0; k < EW; k++)
    begin : g_mul
        lsi_mul_cell #(.IDX(k)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (mval[k]),
            .in_ready  (mrdy[k]),
            .in_data   (mdat[k]),
            .out_valid (mval[k+1]),
            .out_ready (mrdy[k+1]),
            .out_data  (mdat[k+1])
        );
    end

    // Rounding numerator 2n + d, offset by half the range so the quotient is unsigned.
    always_comb
    begin
        nsx = (SW'(mdat[EW].nx) <<< 1) + SW'(mdat[EW].den) + (SW'(mdat[EW].den) <<< CW);
        nsy = (SW'(mdat[EW].ny) <<< 1) + SW'(mdat[EW].den) + (SW'(mdat[EW].den) <<< CW);
        lim = SW'(mdat[EW].den) <<< (CW + 1);
        prep_next.hit  = mdat[EW].hit;
        prep_next.den  = DW'(mdat[EW].den);
        prep_next.rx   = RW'(nsx);
        prep_next.ry   = RW'(nsy);
        prep_next.qx   = '0;
        prep_next.qy   = '0;
        prep_next.hi_x = nsx >= lim;
        prep_next.lo_x = nsx[SW-1];
        prep_next.hi_y = nsy >= lim;
        prep_next.lo_y = nsy[SW-1];
    end

    assign prep_ready = !prep_valid_reg || drdy[0];
    assign mrdy[EW]   = prep_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prep_valid_reg <= 1'b0;
        else if (prep_ready)
            prep_valid_reg <= mval[EW];
    end

    always_ff @(posedge clk)
    begin
        if (prep_ready && mval[EW])
            prep_reg <= prep_next;
    end

    assign dval[0] = prep_valid_reg;
    assign ddat[0] = prep_reg;

    // Divider chain, most significant quotient bit first.
    for (genvar k = 0; k < CW; k++)
    begin : g_div
        lsi_div_cell #(.IDX(CW - 1 - k)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dval[k]),
            .in_ready  (drdy[k]),
            .in_data   (ddat[k]),
            .out_valid (dval[k+1]),
            .out_ready (drdy[k+1]),
            .out_data  (ddat[k+1])
        );
    end

    // Undo the offset, saturate, and zero the word when there is no hit.
    always_comb
    begin
        dlast    = ddat[CW];
        out_next = '0;
        if (dlast.hit)
        begin
            out_next.hit = 1'b1;
            if (dlast.hi_x)
                out_next.cross_x = {1'b0, {(CW-1){1'b1}}};
            else if (dlast.lo_x)
                out_next.cross_x = {1'b1, {(CW-1){1'b0}}};
            else
                out_next.cross_x = {~dlast.qx[CW-1], dlast.qx[CW-2:0]};
            if (dlast.hi_y)
                out_next.cross_y = {1'b0, {(CW-1){1'b1}}};
            else if (dlast.lo_y)
                out_next.cross_y = {1'b1, {(CW-1){1'b0}}};
            else
                out_next.cross_y = {~dlast.qy[CW-1], dlast.qy[CW-2:0]};
            out_next.clipped = dlast.hi_x || dlast.lo_x || dlast.hi_y || dlast.lo_y;
        end
    end

    assign out_ready  = !out_valid_reg || !point_stall;
    assign drdy[CW]   = out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ready)
            out_valid_reg <= dval[CW];
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && dval[CW])
            out_reg <= out_next;
    end

    assign point_valid = out_valid_reg;
    assign point       = out_reg;

    // A word without a hit carries no point and no clip flag.
    a_no_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (point_valid && !point.hit) |->
            (point.cross_x == '0 && point.cross_y == '0 && !point.clipped))
        else $error("no-hit word has nonzero fields");

    // A clipped word has at least one coordinate on a range bound.
    a_clip_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (point_valid && point.clipped) |->
            (point.cross_x == {1'b0, {(CW-1){1'b1}}} ||
             point.cross_x == {1'b1, {(CW-1){1'b0}}} ||
             point.cross_y == {1'b0, {(CW-1){1'b1}}} ||
             point.cross_y == {1'b1, {(CW-1){1'b0}}}))
        else $error("clipped word not on a bound");

    // A full output register that is stalled holds the divider chain end.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && point_stall) |-> !drdy[CW])
        else $error("divider chain drains into a stalled output");

    // With an empty output register the whole chain end can move.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> (drdy[CW] && drdy[CW-1]))
        else $error("empty output does not release the divider chain");

endmodule
